// ===== src/fla_pkg.sv =====
// Shared constants, codes and types of the free-list id allocator.
`timescale 1ns / 1ps

package fla_pkg;

   // Pool geometry (POOL_SIZE sets the pool at 1024 ids and fixes the port widths)
   localparam int unsigned POOL_SIZE   = 1024;
   localparam int unsigned ID_W        = $clog2(POOL_SIZE);
   localparam int unsigned CNT_W       = ID_W + 1;

   // Live bitmap is kept as rows of ROW_W bits
   localparam int unsigned ROW_W       = 32;
   localparam int unsigned BIT_W       = $clog2(ROW_W);
   localparam int unsigned ROWS        = POOL_SIZE / ROW_W;
   localparam int unsigned ROW_IDX_W   = ID_W - BIT_W;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_code_type;

   // Classified command word handed from front to back
   typedef struct packed {
      logic            is_alloc;
      logic            is_free;
      logic            is_query;
      logic            is_clear;
      logic [ID_W-1:0] tid;
   } cmd_type;

endpackage

// ===== src/fla_front.sv =====
// Request front end: accepts words, decodes the op and queues commands.
`timescale 1ns / 1ps

module fla_front
   import fla_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_op,
   input  logic [ID_W-1:0] req_target_id,
   output logic            q_valid,
   output cmd_type         q_item,
   input  logic            q_pop
);

   cmd_type             q_slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_dec;
   logic                push;
   logic                pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      cmd_dec     = '0;
      cmd_dec.tid = req_target_id;
      case (op_code_type'(req_op))
         OP_ALLOC: cmd_dec.is_alloc = 1'b1;
         OP_FREE:  cmd_dec.is_free  = 1'b1;
         OP_QUERY: cmd_dec.is_query = 1'b1;
         OP_CLEAR: cmd_dec.is_clear = 1'b1;
         default:  cmd_dec.is_query = 1'b1;
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_slot_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

// ===== src/fla_back.sv =====
// Back end: sequencer over the free stack, live bitmap and result register.
`timescale 1ns / 1ps

module fla_back
   import fla_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cmd_type          q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_status,
   output logic [ID_W-1:0]  rsp_granted_id,
   output logic             rsp_is_live,
   output logic [CNT_W-1:0] rsp_used_high_water
);

   typedef enum logic [2:0] {
      ST_FETCH,
      ST_PICK,
      ST_MOD,
      ST_LOOK,
      ST_ANS
   } state_type;

   // Storage
   logic [ROW_W-1:0]     live_mem  [ROWS];
   logic [ID_W-1:0]      stack_mem [POOL_SIZE];

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic                 fail_ff, fail_in;
   logic [ID_W-1:0]      granted_ff, granted_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     hw_ff, hw_in;
   logic [ROWS-1:0]      row_vld_ff, row_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_granted_ff, rsp_granted_in;
   logic                 rsp_live_ff, rsp_live_in;
   logic [CNT_W-1:0]     rsp_hw_ff, rsp_hw_in;

   // Memory ports
   logic                 stack_rd_en;
   logic [ID_W-1:0]      stack_rd_addr;
   logic [ID_W-1:0]      stack_rd_data_ff;
   logic                 stack_wr_en;
   logic [ID_W-1:0]      stack_wr_addr;
   logic [ID_W-1:0]      stack_wr_data;
   logic                 live_rd_en;
   logic [ROW_IDX_W-1:0] live_rd_addr;
   logic [ROW_W-1:0]     live_rd_data_ff;
   logic                 live_rd_vld_ff;
   logic                 live_wr_en;
   logic [ROW_IDX_W-1:0] live_wr_addr;
   logic [ROW_W-1:0]     live_wr_data;

   logic [ROW_W-1:0]     row_eff;
   logic [ROW_W-1:0]     id_mask;
   logic [ROW_W-1:0]     tid_mask;

   // Row that was never written since clear reads as all zero
   assign row_eff  = live_rd_vld_ff ? live_rd_data_ff : '0;
   assign id_mask  = ROW_W'(1) << id_ff[BIT_W-1:0];
   assign tid_mask = ROW_W'(1) << cmd_ff.tid[BIT_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      fail_in        = fail_ff;
      granted_in     = granted_ff;
      depth_in       = depth_ff;
      hw_in          = hw_ff;
      row_vld_in     = row_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_hw_in      = rsp_hw_ff;
      q_pop          = 1'b0;
      stack_rd_en    = 1'b0;
      stack_rd_addr  = ID_W'(depth_ff - CNT_W'(1));
      stack_wr_en    = 1'b0;
      stack_wr_addr  = depth_ff[ID_W-1:0];
      stack_wr_data  = cmd_ff.tid;
      live_rd_en     = 1'b0;
      live_rd_addr   = cmd_ff.tid[ID_W-1:BIT_W];
      live_wr_en     = 1'b0;
      live_wr_addr   = id_ff[ID_W-1:BIT_W];
      live_wr_data   = row_eff;

      case (state_ff)
         ST_FETCH: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cmd_in      = q_item;
               fail_in     = 1'b0;
               granted_in  = '0;
               // speculative pop read; only used by an allocate with depth > 0
               stack_rd_en = 1'b1;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_MOD;
            if (cmd_ff.is_alloc) begin
               if (depth_ff != '0) begin
                  id_in    = stack_rd_data_ff;
                  depth_in = depth_ff - CNT_W'(1);
               end else if (hw_ff < CNT_W'(POOL_SIZE)) begin
                  id_in = hw_ff[ID_W-1:0];
                  hw_in = hw_ff + CNT_W'(1);
               end else begin
                  fail_in = 1'b1;
               end
               live_rd_en   = 1'b1;
               live_rd_addr = id_in[ID_W-1:BIT_W];
            end else if (cmd_ff.is_free) begin
               id_in        = cmd_ff.tid;
               live_rd_en   = 1'b1;
               live_rd_addr = cmd_ff.tid[ID_W-1:BIT_W];
            end else if (cmd_ff.is_clear) begin
               row_vld_in = '0;
               depth_in   = '0;
               hw_in      = '0;
               state_in   = ST_LOOK;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_MOD: begin
            state_in = ST_LOOK;
            if (cmd_ff.is_alloc) begin
               if (!fail_ff) begin
                  live_wr_en       = 1'b1;
                  live_wr_data     = row_eff | id_mask;
                  row_vld_in[live_wr_addr] = 1'b1;
                  granted_in       = id_ff;
               end
            end else if ((row_eff & id_mask) != '0) begin
               // free of a live id: clear its bit and push it if the stack has room
               live_wr_en   = 1'b1;
               live_wr_data = row_eff & ~id_mask;
               if (depth_ff < CNT_W'(POOL_SIZE)) begin
                  stack_wr_en = 1'b1;
                  depth_in    = depth_ff + CNT_W'(1);
               end
            end else begin
               fail_in = 1'b1;
            end
         end
         ST_LOOK: begin
            live_rd_en = 1'b1;
            state_in   = ST_ANS;
         end
         ST_ANS: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = fail_ff;
               rsp_granted_in = granted_ff;
               rsp_live_in    = (row_eff & tid_mask) != '0;
               rsp_hw_in      = hw_ff;
               state_in       = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         depth_ff     <= '0;
         hw_ff        <= '0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         hw_ff        <= hw_in;
         row_vld_ff   <= row_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      fail_ff        <= fail_in;
      granted_ff     <= granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_hw_ff      <= rsp_hw_in;
   end

   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[stack_wr_addr] <= stack_wr_data;
      end
      if (stack_rd_en) begin
         stack_rd_data_ff <= stack_mem[stack_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (live_wr_en) begin
         live_mem[live_wr_addr] <= live_wr_data;
      end
      if (live_rd_en) begin
         live_rd_data_ff <= live_mem[live_rd_addr];
         live_rd_vld_ff  <= row_vld_ff[live_rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_id      = rsp_granted_ff;
   assign rsp_is_live         = rsp_live_ff;
   assign rsp_used_high_water = rsp_hw_ff;

endmodule

// ===== src/free_list_id_allocator_core.sv =====
// Top level of the free-list id allocator: front queue plus back sequencer.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  req_op, req_target_id
//   rsp_     out        rsp_valid/rsp_stall  rsp_status, rsp_granted_id,
//                                            rsp_is_live, rsp_used_high_water
//
// Steps: the back sequencer takes an allocate or free word through fetch, pick,
//   modify, look up and answer, and a query or clear word through the same steps
//   without modify; the steps are chained by registered reads of the free stack
//   or live bitmap memory, and a new word is fetched only after the answer step.
// The front queues up to 2 words ahead, so requests are still accepted while a
//   result waits in the output register, until the queue is full.
// Reset: synchronous, active high. Per-row valid flops clear the bitmap at
//   once, so no clearing pass follows reset; a clear op does the same.
// A stalled result holds the sequencer in its answer step only.
`timescale 1ns / 1ps

module free_list_id_allocator_core
   import fla_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [ID_W-1:0]  req_target_id,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_status,
   output logic [ID_W-1:0]  rsp_granted_id,
   output logic             rsp_is_live,
   output logic [CNT_W-1:0] rsp_used_high_water
);

   // front -> back command queue head
   logic    q_valid;
   cmd_type q_item;
   logic    q_pop;

   fla_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_target_id (req_target_id),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // back: stack pop/push, bitmap read-modify-write, result register
   fla_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_id      (rsp_granted_id),
      .rsp_is_live         (rsp_is_live),
      .rsp_used_high_water (rsp_used_high_water)
   );

endmodule

// ===== src/fla_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`timescale 1ns / 1ps

module fla_checker
   import fla_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_status,
   input logic [ID_W-1:0]  rsp_granted_id,
   input logic             rsp_is_live,
   input logic [CNT_W-1:0] rsp_used_high_water
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_id) && $stable(rsp_is_live)
         && $stable(rsp_used_high_water))
      else $error("result word changed under stall");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_granted_id == '0)
      else $error("failed word carries a granted id");

   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_high_water <= CNT_W'(POOL_SIZE))
      else $error("high water beyond pool");

   a_grant_below_hw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_id != '0
         |-> CNT_W'(rsp_granted_id) < rsp_used_high_water)
      else $error("granted id not below high water");

endmodule

bind free_list_id_allocator_core fla_checker u_fla_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_granted_id      (rsp_granted_id),
   .rsp_is_live         (rsp_is_live),
   .rsp_used_high_water (rsp_used_high_water)
);
